// File: rtl/lsr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the looping sample resampler
// no dependencies; used by the top level and its checker

package lsr_pkg;

    // default storage and fixed-point format
    localparam int SAMPLE_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF    = 16;

    // field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int ADDR_FLD_W = 16;
    localparam int POS_FLD_W  = 32;
    localparam int LOOP_W     = 16;
    localparam int FCOUNT_W   = 17;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam logic [POS_FLD_W-1:0] STEP_RESET = 32'h0001_0000;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_TICK = 2'd1,
        REQ_SET  = 2'd2
    } t_req_type;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP        = 2'd0,
        CFG_LOOP_BEGIN  = 2'd1,
        CFG_LOOP_END    = 2'd2,
        CFG_FRAME_COUNT = 2'd3
    } t_cfg_index;

endpackage

// File: rtl/looping_sample_resampler.sv
`timescale 1ns / 1ps
// looping sample-playback voice with linear interpolation
// depends on lsr_pkg; sample store is a dual-read memory inside this module
//
// One request is taken per clock, every clock, as long as the result path is not
// stalled. A load request writes one signed sample, a set request places the
// unsigned fixed-point read position (FRAC_BITS fraction bits), and a tick request
// gives one interpolated sample and then advances the position by the step,
// wrapping from loop_end back to loop_begin when loop_begin < loop_end. A tick's
// result passes the tap registers, which read both taps from the two read ports
// of the sample memory (registered read data), and then the output stage, which
// does the single multiply of the interpolation into the output register. Loads
// and sets give no result. SAMPLE_DEPTH must be a power of two; tap indexes wrap
// modulo the depth and loads beyond it are dropped. Store entries are not cleared
// at reset and hold nothing defined until loaded. Configuration writes are meant
// for idle periods only.

module looping_sample_resampler #(
    parameter int SAMPLE_DEPTH = lsr_pkg::SAMPLE_DEPTH_DEF,
    parameter int FRAC_BITS    = lsr_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [lsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lsr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,

    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // sample_addr[15:0], sample_value[31:16],
                                          // start_position[63:32]
    input  logic [1:0]  i_s_axis_tuser,   // req_type[1:0]

    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // sample_out[15:0]
    output logic        o_m_axis_tuser    // past_end[0]
);

    // address and arithmetic widths
    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int IDX_W  = 32 - FRAC_BITS;
    localparam int EXT_A  = (ADDR_W > IDX_W + 1) ? ADDR_W : IDX_W + 1;
    localparam int EXT_W  = (EXT_A > lsr_pkg::FCOUNT_W) ? EXT_A : lsr_pkg::FCOUNT_W;
    localparam int POS_W  = (lsr_pkg::LOOP_W + FRAC_BITS > 33) ?
                            lsr_pkg::LOOP_W + FRAC_BITS : 33;
    localparam int PROD_W = FRAC_BITS + 18;
    localparam logic [EXT_W:0]          DEPTH_C = (EXT_W + 1)'(SAMPLE_DEPTH);
    localparam logic signed [PROD_W-1:0] HALF_C = PROD_W'(1) <<< (FRAC_BITS - 1);

    // request fields
    lsr_pkg::t_req_type w_req;
    logic [15:0]        w_addr_fld;
    logic [15:0]        w_value_fld;
    logic [31:0]        w_start_fld;
    logic               w_acc;

    assign w_req       = lsr_pkg::t_req_type'(i_s_axis_tuser);
    assign w_addr_fld  = i_s_axis_tdata[15:0];
    assign w_value_fld = i_s_axis_tdata[31:16];
    assign w_start_fld = i_s_axis_tdata[63:32];

    // configuration registers
    logic [31:0] r_step;
    logic [15:0] r_loop_begin;
    logic [15:0] r_loop_end;
    logic [16:0] r_frame_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= lsr_pkg::STEP_RESET;
            r_loop_begin  <= '0;
            r_loop_end    <= '0;
            r_frame_count <= '0;
        end else if (i_cfg_wr_en) begin
            case (lsr_pkg::t_cfg_index'(i_cfg_index))
                lsr_pkg::CFG_STEP:        r_step        <= i_cfg_wdata;
                lsr_pkg::CFG_LOOP_BEGIN:  r_loop_begin  <= i_cfg_wdata[15:0];
                lsr_pkg::CFG_LOOP_END:    r_loop_end    <= i_cfg_wdata[15:0];
                lsr_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // pipeline flow: output register, then the tap stage
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s2_adv;
    logic w_s1_adv;

    assign w_s2_adv        = !r_out_valid || i_m_axis_tready;
    assign w_s1_adv        = !r_s1_valid || w_s2_adv;
    assign o_s_axis_tready = w_s1_adv;
    assign w_acc           = i_s_axis_tvalid && w_s1_adv;

    // ---------------- stage 0: tap addresses and position advance ----------------
    logic [31:0]          r_pos;
    logic                 w_looping;
    logic [EXT_W-1:0]     w_idx_raw;
    logic [EXT_W-1:0]     w_loop_end_e;
    logic [EXT_W-1:0]     w_loop_begin_e;
    logic [EXT_W-1:0]     w_idx;
    logic [EXT_W-1:0]     w_idx_next;
    logic                 w_clamp;
    logic                 w_wrap;
    logic                 w_past;
    logic [FRAC_BITS-1:0] w_frac;
    logic [ADDR_W-1:0]    w_addr_a;
    logic [ADDR_W-1:0]    w_addr_b;

    assign w_looping      = r_loop_begin < r_loop_end;
    assign w_idx_raw      = EXT_W'(r_pos[31:FRAC_BITS]);
    assign w_loop_end_e   = EXT_W'(r_loop_end);
    assign w_loop_begin_e = EXT_W'(r_loop_begin);
    // whole-sample compares stand in for the fixed-point ones
    assign w_clamp        = w_looping && (w_idx_raw > w_loop_end_e);
    assign w_wrap         = w_looping && (w_idx_raw >= w_loop_end_e);
    assign w_idx          = w_clamp ? w_loop_end_e : w_idx_raw;
    assign w_idx_next     = w_idx + EXT_W'(1);
    assign w_addr_a       = w_idx[ADDR_W-1:0];
    assign w_addr_b       = w_wrap ? w_loop_begin_e[ADDR_W-1:0] : w_idx_next[ADDR_W-1:0];
    // a clamped index leaves at least one whole sample of fraction: saturate
    assign w_frac         = w_clamp ? '1 : r_pos[FRAC_BITS-1:0];
    // empty or one-sample store is always past the end
    assign w_past         = (r_frame_count <= 17'd1) ||
                            (w_idx_raw >= EXT_W'(r_frame_count - 17'd1));

    // advance: saturating add, then one wrap of the overshoot past loop_end
    logic [32:0]      w_sum;
    logic [31:0]      w_sat;
    logic [POS_W-1:0] w_sat_e;
    logic [POS_W-1:0] w_end_p;
    logic [POS_W-1:0] w_begin_p;
    logic [POS_W-1:0] w_wrapped;
    logic [31:0]      n_pos;

    assign w_sum     = {1'b0, r_pos} + {1'b0, r_step};
    assign w_sat     = w_sum[32] ? '1 : w_sum[31:0];
    assign w_sat_e   = POS_W'(w_sat);
    assign w_end_p   = POS_W'(r_loop_end) << FRAC_BITS;
    assign w_begin_p = POS_W'(r_loop_begin) << FRAC_BITS;
    assign w_wrapped = w_begin_p + (w_sat_e - w_end_p);
    assign n_pos     = (w_looping && (w_sat_e > w_end_p)) ? w_wrapped[31:0] : w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_acc) begin
            case (w_req)
                lsr_pkg::REQ_TICK: r_pos <= n_pos;
                lsr_pkg::REQ_SET:  r_pos <= w_start_fld;
                default: ;
            endcase
        end
    end

    // sample store: one write port, two registered read ports
    logic [15:0] r_mem [SAMPLE_DEPTH];
    logic        w_load;

    assign w_load = w_acc && (w_req == lsr_pkg::REQ_LOAD) &&
                    ({1'b0, EXT_W'(w_addr_fld)} < DEPTH_C);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[w_addr_fld[ADDR_W-1:0]] <= w_value_fld;
        end
    end

    // ---------------- stage 1: taps ----------------
    logic signed [15:0]   r_tap_a;
    logic signed [15:0]   r_tap_b;
    logic [FRAC_BITS-1:0] r_s1_frac;
    logic                 r_s1_past;

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_tap_a   <= r_mem[w_addr_a];
            r_tap_b   <= r_mem[w_addr_b];
            r_s1_frac <= w_frac;
            r_s1_past <= w_past;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= w_acc && (w_req == lsr_pkg::REQ_TICK);
        end
    end

    // interpolation: a + floor((frac * (b - a) + half) / 2^FRAC_BITS)
    logic signed [16:0]          w_diff;
    logic signed [FRAC_BITS:0]   w_frac_s;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [PROD_W-1:0]    w_shift;
    logic [15:0]                 w_interp;

    assign w_diff   = 17'(r_tap_b) - 17'(r_tap_a);
    assign w_frac_s = signed'({1'b0, r_s1_frac});
    assign w_prod   = PROD_W'(w_frac_s) * PROD_W'(w_diff);
    assign w_shift  = (w_prod + HALF_C) >>> FRAC_BITS;
    // true result lies between the taps, so 16-bit wrap is exact
    assign w_interp = r_tap_a + w_shift[15:0];

    // ---------------- stage 2: output register ----------------
    logic [15:0] r_out_data;
    logic        r_out_past;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_data <= r_s1_past ? '0 : w_interp;
            r_out_past <= r_s1_past;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_past;

endmodule

// File: rtl/lsr_checker.sv
`timescale 1ns / 1ps
// port-level checks of the looping sample resampler, bound to the top level
// depends on lsr_pkg and looping_sample_resampler

module lsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    logic w_tick_acc;

    assign w_tick_acc = i_s_axis_tvalid && o_s_axis_tready &&
                        (i_s_axis_tuser == lsr_pkg::REQ_TICK);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // a newly valid result only ever follows an accepted tick request
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_tick_acc, 2))
        else $error("result without a tick request");

    // past the end the sample is zero
    a_past_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 16'd0)
        else $error("nonzero sample past end");

    // an empty output register never blocks requests
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("request blocked with empty output");

endmodule

bind looping_sample_resampler lsr_checker u_lsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
